>>> hw/rtl/dilv_pkg.sv
// ----------------------------------------------------------------------------
// dilv_pkg: shared types and constants for the decimal integer list validator
// Transaction payloads, status codes, store sizing and queue sizing.
// ----------------------------------------------------------------------------
package dilv_pkg;

    localparam int MAX_ENTRIES = 512;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int VAL_W       = 32;
    localparam int POS_W       = 10;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QLVL_W = $clog2(QDEPTH + 1);

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_NEW  = 2'd2;

    localparam logic [2:0] STAT_ACCEPT    = 3'd0;
    localparam logic [2:0] STAT_MALFORMED = 3'd1;
    localparam logic [2:0] STAT_RANGE     = 3'd2;
    localparam logic [2:0] STAT_DUP       = 3'd3;
    localparam logic [2:0] STAT_FULL      = 3'd4;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
    } in_t;

    typedef struct packed {
        logic [2:0]              status;
        logic signed [VAL_W-1:0] number;
        logic [POS_W-1:0]        position;
    } out_t;

    // front -> back command: end of argument (with pre-check) or new list
    typedef struct packed {
        logic             is_end;
        logic [2:0]       status;
        logic [VAL_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             busy;
    } back_stat_t;

endpackage

>>> hw/rtl/decimal_int_list_validator.sv
// ----------------------------------------------------------------------------
// decimal_int_list_validator: signed decimal integer list checker
// Input transactions carry one argument character, an end-of-argument marker
// or a new-list marker. Each end-of-argument produces one output transaction
// with status (accepted, malformed, out of range, duplicate, full), the value
// and its list position. Characters and new-list markers produce no output.
// Characters are taken one per cycle while the command queue is not full.
// End and new-list markers go through a two-entry command queue to the store
// engine, which scans the stored values through the single RAM read port, one
// entry per cycle. With the engine idle and the queue empty, the result of an
// erroneous argument goes from the queue via the emit state to the output
// register; a valid one first runs the scan (a duplicate ends it early).
// in_ready drops only while the queue is full. A stalled receiver holds the
// output register, then the engine, then the queue, then the input. Reset
// empties the list, the queue and the scanner; no clearing pass is needed.
// ----------------------------------------------------------------------------
module decimal_int_list_validator (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  dilv_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output dilv_pkg::out_t out_data
);

    logic                        q_push;
    logic                        q_pop;
    logic                        q_full;
    dilv_pkg::cmd_t              q_cmd;
    dilv_pkg::cmd_t              q_head;
    logic [dilv_pkg::QLVL_W-1:0] q_level;
    dilv_pkg::back_stat_t        back_stat;

    assign q_full = (q_level == dilv_pkg::QLVL_W'(dilv_pkg::QDEPTH));

    dilv_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    dilv_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .level    (q_level)
    );

    dilv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_level   (q_level),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .stat      (back_stat)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        back_stat.count <= dilv_pkg::CNT_W'(dilv_pkg::MAX_ENTRIES))
        else $error("entry count above store size");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_level <= dilv_pkg::QLVL_W'(dilv_pkg::QDEPTH))
        else $error("command queue overflow");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (q_level != '0))
        else $error("pop from empty command queue");

    a_err_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status != dilv_pkg::STAT_ACCEPT)
        |-> (out_data.position == '0))
        else $error("position set on non-accepted result");

    a_idle_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (q_level == '0) |-> !back_stat.busy)
        else $error("store engine busy without a command");

endmodule

>>> hw/rtl/dilv_ram.sv
// ----------------------------------------------------------------------------
// dilv_ram: generic single-write, single-read RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module dilv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/dilv_front.sv
// ----------------------------------------------------------------------------
// dilv_front: argument character scanner
// Accepts input transactions, parses sign and digits with range check, and
// queues one command per end-of-argument or new-list transaction.
// ----------------------------------------------------------------------------
module dilv_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  dilv_pkg::in_t  in_data,
    input  logic           q_full,
    output logic           q_push,
    output dilv_pkg::cmd_t q_cmd
);

    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_SIGN   = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_DIGITS = 3'd3;
    localparam logic [2:0] PH_BAD    = 3'd4;

    logic [2:0]  phase_reg, phase_next;
    logic        neg_reg, neg_next;
    logic [31:0] mag_reg, mag_next;
    logic        range_reg, range_next;

    logic        acc;
    logic        digit;
    logic [3:0]  dval;
    logic [34:0] prod;
    logic [34:0] limit;
    logic [2:0]  lead_phase;

    assign in_ready = !q_full;
    assign acc      = in_valid && in_ready;
    assign digit    = (in_data.ch >= 8'h30) && (in_data.ch <= 8'h39);
    assign dval     = 4'(in_data.ch - 8'h30);
    assign prod     = ({3'b000, mag_reg} << 3) + ({3'b000, mag_reg} << 1) + {31'd0, dval};
    assign limit    = neg_reg ? 35'h0_8000_0000 : 35'h0_7FFF_FFFF;

    always_comb
    begin
        if (in_data.ch == 8'h30)
        begin
            lead_phase = PH_ZERO;
        end
        else if (digit)
        begin
            lead_phase = PH_DIGITS;
        end
        else
        begin
            lead_phase = PH_BAD;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        range_next = range_reg;
        q_push     = 1'b0;
        q_cmd      = '0;
        if (acc)
        begin
            case (in_data.kind)
                dilv_pkg::KIND_CHAR:
                begin
                    if (!range_reg && phase_reg != PH_BAD)
                    begin
                        case (phase_reg)
                            PH_START:
                            begin
                                if (in_data.ch == 8'h2D)
                                begin
                                    neg_next   = 1'b1;
                                    phase_next = PH_SIGN;
                                end
                                else if (in_data.ch == 8'h2B)
                                begin
                                    phase_next = PH_SIGN;
                                end
                                else
                                begin
                                    phase_next = lead_phase;
                                    mag_next   = {28'd0, dval};
                                end
                            end
                            PH_SIGN:
                            begin
                                phase_next = lead_phase;
                                mag_next   = {28'd0, dval};
                            end
                            PH_DIGITS:
                            begin
                                if (!digit)
                                begin
                                    phase_next = PH_BAD;
                                end
                                else if (prod > limit)
                                begin
                                    range_next = 1'b1;
                                end
                                else
                                begin
                                    mag_next = prod[31:0];
                                end
                            end
                            default:
                            begin
                                phase_next = PH_BAD;
                            end
                        endcase
                    end
                end
                dilv_pkg::KIND_END:
                begin
                    q_push       = 1'b1;
                    q_cmd.is_end = 1'b1;
                    if (phase_reg == PH_BAD || phase_reg == PH_START || phase_reg == PH_SIGN)
                    begin
                        q_cmd.status = dilv_pkg::STAT_MALFORMED;
                    end
                    else if (range_reg)
                    begin
                        q_cmd.status = dilv_pkg::STAT_RANGE;
                    end
                    else
                    begin
                        q_cmd.status = dilv_pkg::STAT_ACCEPT;
                        q_cmd.value  = neg_reg ? (32'd0 - mag_reg) : mag_reg;
                    end
                    phase_next = PH_START;
                    neg_next   = 1'b0;
                    mag_next   = '0;
                    range_next = 1'b0;
                end
                dilv_pkg::KIND_NEW:
                begin
                    q_push       = 1'b1;
                    q_cmd.is_end = 1'b0;
                    phase_next   = PH_START;
                    neg_next     = 1'b0;
                    mag_next     = '0;
                    range_next   = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
            range_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
            range_reg <= range_next;
        end
    end

endmodule

>>> hw/rtl/dilv_queue.sv
// ----------------------------------------------------------------------------
// dilv_queue: scanner to store engine command queue, a small register FIFO.
// Users push only when not full, pop only when not empty; neither is checked.
// ----------------------------------------------------------------------------
module dilv_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  dilv_pkg::cmd_t              push_cmd,
    input  logic                        pop,
    output dilv_pkg::cmd_t              head,
    output logic [dilv_pkg::QLVL_W-1:0] level
);

    dilv_pkg::cmd_t                entry_reg [dilv_pkg::QDEPTH];
    logic [dilv_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [dilv_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [dilv_pkg::QLVL_W-1:0]   level_reg, level_next;

    localparam logic [dilv_pkg::QPTR_W-1:0] LAST = dilv_pkg::QPTR_W'(dilv_pkg::QDEPTH - 1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign level = level_reg;

endmodule

>>> hw/rtl/dilv_back.sv
// ----------------------------------------------------------------------------
// dilv_back: value store engine
// Runs queued commands: duplicate scan over the stored values, append,
// store clear, and result transaction into the output register.
// ----------------------------------------------------------------------------
module dilv_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [dilv_pkg::QLVL_W-1:0] q_level,
    input  dilv_pkg::cmd_t              q_head,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output dilv_pkg::out_t              out_data,
    output dilv_pkg::back_stat_t        stat
);

    localparam logic [1:0] BK_IDLE = 2'd0;
    localparam logic [1:0] BK_SCAN = 2'd1;
    localparam logic [1:0] BK_EMIT = 2'd2;

    localparam logic [dilv_pkg::CNT_W-1:0] FULL_CNT =
        dilv_pkg::CNT_W'(dilv_pkg::MAX_ENTRIES);

    logic [1:0]                   state_reg, state_next;
    logic [dilv_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [dilv_pkg::CNT_W-1:0]   idx_reg, idx_next;
    logic                         chk_reg, chk_next;
    logic [2:0]                   res_status_reg, res_status_next;
    logic [dilv_pkg::VAL_W-1:0]   res_number_reg, res_number_next;
    logic                         out_valid_reg, out_valid_next;
    dilv_pkg::out_t               out_data_reg, out_data_next;

    logic                         rd_en;
    logic [dilv_pkg::ADDR_W-1:0]  rd_addr;
    logic [dilv_pkg::VAL_W-1:0]   rd_data;
    logic                         wr_en;
    logic                         hit;
    logic                         slot_free;

    assign hit       = chk_reg && (rd_data == q_head.value);
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        chk_next        = chk_reg;
        res_status_next = res_status_reg;
        res_number_next = res_number_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        q_pop           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = idx_reg[dilv_pkg::ADDR_W-1:0];
        wr_en           = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            BK_IDLE:
            begin
                if (q_level != '0)
                begin
                    if (!q_head.is_end)
                    begin
                        count_next = '0;
                        q_pop      = 1'b1;
                    end
                    else if (q_head.status != dilv_pkg::STAT_ACCEPT)
                    begin
                        res_status_next = q_head.status;
                        res_number_next = '0;
                        state_next      = BK_EMIT;
                    end
                    else
                    begin
                        idx_next   = '0;
                        chk_next   = 1'b0;
                        state_next = BK_SCAN;
                    end
                end
            end
            BK_SCAN:
            begin
                if (hit)
                begin
                    res_status_next = dilv_pkg::STAT_DUP;
                    res_number_next = q_head.value;
                    chk_next        = 1'b0;
                    state_next      = BK_EMIT;
                end
                else if (idx_reg < count_reg)
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + 1'b1;
                    chk_next = 1'b1;
                end
                else
                begin
                    chk_next = 1'b0;
                    if (count_reg == FULL_CNT)
                    begin
                        res_status_next = dilv_pkg::STAT_FULL;
                        res_number_next = '0;
                    end
                    else
                    begin
                        res_status_next = dilv_pkg::STAT_ACCEPT;
                        res_number_next = q_head.value;
                    end
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next         = 1'b1;
                    out_data_next.status   = res_status_reg;
                    out_data_next.number   = res_number_reg;
                    out_data_next.position = '0;
                    if (res_status_reg == dilv_pkg::STAT_ACCEPT)
                    begin
                        wr_en                  = 1'b1;
                        out_data_next.position = dilv_pkg::POS_W'(count_reg);
                        count_next             = count_reg + 1'b1;
                    end
                    else
                    begin
                        count_next = '0;
                    end
                    q_pop      = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            chk_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            chk_reg       <= chk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_number_reg <= res_number_next;
        out_data_reg   <= out_data_next;
    end

    dilv_ram #(
        .WIDTH (dilv_pkg::VAL_W),
        .DEPTH (dilv_pkg::MAX_ENTRIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[dilv_pkg::ADDR_W-1:0]),
        .wr_data (res_number_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign stat.count = count_reg;
    assign stat.busy  = (state_reg != BK_IDLE);

endmodule

>>> dv/dilv_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dilv_list_checker: transaction checker for the decimal integer list validator
// Watches both channels, tracks the argument scan and the stored value list,
// and compares every output transaction with the oldest predicted one.
// ----------------------------------------------------------------------------
module dilv_list_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_ready,
    input  dilv_pkg::in_t  in_data,
    input  logic           out_valid,
    input  logic           out_ready,
    input  dilv_pkg::out_t out_data,
    output int             fail_count,
    output int             outstanding
);
    import dilv_pkg::*;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;

    localparam logic [63:0] POS_LIMIT = 64'd2147483647;
    localparam logic [63:0] NEG_LIMIT = 64'd2147483648;

    typedef enum logic [2:0] {
        SCAN_START,
        SCAN_SIGN,
        SCAN_ZERO,
        SCAN_DIGITS,
        SCAN_BAD
    } scan_e;

    scan_e       phase     = SCAN_START;
    logic        negative  = 1'b0;
    logic [31:0] magnitude = '0;
    logic        overflow  = 1'b0;
    logic [31:0] list_vals [MAX_ENTRIES];
    int          list_len  = 0;
    out_t        awaited_results[$];
    int          results_seen = 0;
    int          failures = 0;
    int          pending  = 0;

    assign fail_count  = failures;
    assign outstanding = pending;

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        failures++;
        $display("mismatch on %s, result %0d: expected %h, got %h",
                 what, results_seen, want, got);
    endtask

    task automatic clear_scan();
        phase     = SCAN_START;
        negative  = 1'b0;
        magnitude = '0;
        overflow  = 1'b0;
    endtask

    task automatic scan_char(input logic [7:0] c);
        logic [63:0] grown;
        logic [63:0] limit;
        logic        is_digit;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if (!overflow && phase != SCAN_BAD)
        begin
            if (phase == SCAN_START && c == CH_MINUS)
            begin
                negative = 1'b1;
                phase    = SCAN_SIGN;
            end
            else if (phase == SCAN_START && c == CH_PLUS)
            begin
                phase = SCAN_SIGN;
            end
            else if (phase == SCAN_START || phase == SCAN_SIGN)
            begin
                if (c == CH_ZERO)
                    phase = SCAN_ZERO;
                else if (is_digit)
                begin
                    phase     = SCAN_DIGITS;
                    magnitude = 32'(c - CH_ZERO);
                end
                else
                    phase = SCAN_BAD;
            end
            else if (phase == SCAN_DIGITS)
            begin
                if (is_digit)
                begin
                    limit = negative ? NEG_LIMIT : POS_LIMIT;
                    grown = {32'd0, magnitude} * 64'd10 + 64'(c - CH_ZERO);
                    if (grown > limit)
                        overflow = 1'b1;
                    else
                        magnitude = grown[31:0];
                end
                else
                    phase = SCAN_BAD;
            end
            else
                phase = SCAN_BAD;
        end
    endtask

    task automatic close_argument();
        out_t        verdict;
        logic [31:0] value;
        logic        hit;
        verdict = '0;
        hit     = 1'b0;
        if (phase == SCAN_BAD || phase == SCAN_START || phase == SCAN_SIGN)
            verdict.status = STAT_MALFORMED;
        else if (overflow)
            verdict.status = STAT_RANGE;
        else
        begin
            value = negative ? -magnitude : magnitude;
            for (int i = 0; i < list_len; i++)
            begin
                if (list_vals[i] == value)
                    hit = 1'b1;
            end
            if (hit)
            begin
                verdict.status = STAT_DUP;
                verdict.number = value;
            end
            else if (list_len >= MAX_ENTRIES)
                verdict.status = STAT_FULL;
            else
            begin
                list_vals[list_len] = value;
                verdict.status      = STAT_ACCEPT;
                verdict.number      = value;
                verdict.position    = POS_W'(list_len);
                list_len++;
            end
        end
        if (verdict.status != STAT_ACCEPT)
            list_len = 0;
        clear_scan();
        awaited_results.push_back(verdict);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_scan();
            list_len = 0;
            awaited_results.delete();
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                case (in_data.kind)
                    KIND_CHAR: scan_char(in_data.ch);
                    KIND_END:  close_argument();
                    KIND_NEW:
                    begin
                        clear_scan();
                        list_len = 0;
                    end
                    default: ;
                endcase
            end
            if ($isunknown(out_valid))
                note_mismatch("out_valid", 32'd0, 32'(out_valid));
            else if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                    note_mismatch("unexpected transaction", 32'd0, 32'(out_data.status));
                else
                begin
                    out_t want;
                    want = awaited_results.pop_front();
                    if (out_data.status !== want.status)
                        note_mismatch("status", 32'(want.status), 32'(out_data.status));
                    if (out_data.number !== want.number)
                        note_mismatch("number", want.number, out_data.number);
                    if (out_data.position !== want.position)
                        note_mismatch("position", 32'(want.position),
                                      32'(out_data.position));
                end
                results_seen++;
            end
        end
        pending = awaited_results.size();
    end

endmodule

>>> dv/decimal_int_list_validator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_int_list_validator_test: testbench top for the list validator
// Drives directed arguments, two full-list runs and a random mix of valid,
// malformed and out-of-range arguments with bursty input and a stalling
// receiver; the checker predicts and compares every output transaction.
// ----------------------------------------------------------------------------
module decimal_int_list_validator_test;
    import dilv_pkg::*;

    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS  = 1150;
    localparam int         CYCLE_LIMIT   = 2000000;
    localparam int         SETTLE_CYCLES = 600;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;
    int   fail_count;
    int   outstanding;

    logic [7:0] arg_text[$];
    int         recent_vals[$];
    int         items_sent  = 0;
    int         burst_left  = 0;
    int         cycle_count = 0;

    decimal_int_list_validator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    dilv_list_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin : receiver
        int mode;
        int span;
        int tick;
        mode      = 0;
        span      = 0;
        tick      = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (span == 0)
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(32, 300);
            end
            span--;
            tick++;
            case (mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 3) != 0);
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ((tick % 23) >= 17);
            endcase
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic drive(input logic [1:0] k, input logic [7:0] c);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 200)
                                                     : $urandom_range(1, 32);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= {k, c};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        if (k != KIND_UNUSED)
            items_sent++;
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        wait (outstanding == 0);
        @(negedge clk);
    endtask

    task automatic put_string(input string s);
        for (int i = 0; i < s.len(); i++)
            arg_text.push_back(s[i]);
    endtask

    task automatic put_number(input bit neg, input bit plus, input longint mag,
                              input bit lead_zero);
        if (neg)
            put_string("-");
        else if (plus)
            put_string("+");
        if (lead_zero)
            put_string("0");
        put_string($sformatf("%0d", mag));
    endtask

    task automatic put_value(input int v, input bit plus);
        longint mag;
        mag = (v < 0) ? -longint'(v) : longint'(v);
        put_number(v < 0, plus, mag, 1'b0);
    endtask

    // sends the staged text, with an optional extra byte before index junk_at
    task automatic send_arg(input int junk_at, input logic [7:0] junk);
        for (int i = 0; i <= arg_text.size(); i++)
        begin
            if (i == junk_at)
                drive(KIND_CHAR, junk);
            if (i < arg_text.size())
                drive(KIND_CHAR, arg_text[i]);
        end
        drive(KIND_END, 8'($urandom));
        arg_text.delete();
    endtask

    function automatic logic [7:0] pick_byte();
        string pool;
        pool = "0123456789-+";
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return pool[$urandom_range(0, 11)];
            4:          return 8'h00;
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic remember(input int v);
        recent_vals.push_back(v);
        if (recent_vals.size() > 24)
            void'(recent_vals.pop_front());
    endtask

    task automatic rand_arg();
        int         r;
        int         shape;
        int         v;
        bit         neg;
        longint     mag;
        int         junk_at;
        logic [7:0] junk;
        junk_at = -1;
        junk    = 8'h00;
        neg     = $urandom_range(0, 1);
        r       = $urandom_range(0, 99);
        if (r < 62)
        begin
            shape = $urandom_range(0, 4);
            case (shape)
                0:       mag = $urandom_range(0, 9);
                1:       mag = $urandom_range(0, 999);
                2:       mag = longint'($urandom & 32'h7fffffff);
                3:       mag = (neg ? 64'd2147483648 : 64'd2147483647)
                               - $urandom_range(0, 3);
                default:
                begin
                    if (recent_vals.size() > 0)
                    begin
                        v   = recent_vals[$urandom_range(0, recent_vals.size() - 1)];
                        neg = (v < 0);
                        mag = neg ? -longint'(v) : longint'(v);
                    end
                    else
                        mag = $urandom_range(0, 99);
                end
            endcase
            if (mag == 0 && neg && $urandom_range(0, 1))
                neg = 1'b0;
            put_number(neg, !neg && ($urandom_range(0, 3) == 0), mag, 1'b0);
            remember(neg ? int'(-mag) : int'(mag));
        end
        else if (r < 70)
        begin
            mag = (neg ? 64'd2147483649 : 64'd2147483648)
                  + ($urandom_range(0, 1) ? longint'($urandom_range(0, 20))
                                          : longint'($urandom) * 3);
            put_number(neg, !neg && $urandom_range(0, 1), mag, 1'b0);
            if ($urandom_range(0, 2) == 0)
            begin
                junk_at = arg_text.size();
                junk    = pick_byte();
            end
        end
        else
        begin
            shape = $urandom_range(0, 5);
            case (shape)
                0:
                begin
                    case ($urandom_range(0, 2))
                        0:       ;
                        1:       put_string("-");
                        default: put_string("+");
                    endcase
                end
                1:
                    put_number(neg, $urandom_range(0, 1), $urandom_range(1, 99999), 1'b1);
                2:
                begin
                    put_number(neg, $urandom_range(0, 1), $urandom_range(0, 99999), 1'b0);
                    junk_at = $urandom_range(0, arg_text.size());
                    junk    = ($urandom_range(0, 3) == 0) ? 8'h00
                                                          : 8'($urandom_range(0, 255));
                end
                3:
                begin
                    repeat ($urandom_range(1, 6))
                        arg_text.push_back(pick_byte());
                end
                4:
                begin
                    put_string($urandom_range(0, 1) ? "-" : "+");
                    put_number(neg, !neg, $urandom_range(0, 999), 1'b0);
                end
                default:
                    put_number(neg, $urandom_range(0, 1), 0, 1'b1);
            endcase
        end
        send_arg(junk_at, junk);
    endtask

    task automatic fill_list(input int base, input int extra);
        drive(KIND_NEW, 8'($urandom));
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            put_value(base + i, $urandom_range(0, 1));
            send_arg(-1, 8'h00);
        end
        put_value(extra, 1'b0);
        send_arg(-1, 8'h00);
    endtask

    initial
    begin : stimulus
        int start_items;
        int arg_no;
        int r;
        int base;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        drive(KIND_NEW, 8'hff);
        put_string("0");           send_arg(-1, 8'h00);
        put_string("-0");          send_arg(-1, 8'h00);
        put_string("+0");          send_arg(-1, 8'h00);
        drive(KIND_NEW, 8'h00);
        put_string("2147483647");  send_arg(-1, 8'h00);
        put_string("-2147483648"); send_arg(-1, 8'h00);
        put_string("2147483648");  send_arg(-1, 8'h00);
        put_string("-2147483649"); send_arg(-1, 8'h00);
        send_arg(-1, 8'h00);
        put_string("-");           send_arg(-1, 8'h00);
        put_string("+");           send_arg(-1, 8'h00);
        put_string("007");         send_arg(-1, 8'h00);
        put_string("-01");         send_arg(-1, 8'h00);
        put_string("12a");         send_arg(-1, 8'h00);
        put_string("99999999999x"); send_arg(-1, 8'h00);
        put_string("99999999999"); send_arg(0, "x");
        put_string("5");           send_arg(1, 8'h00);
        put_string("--5");         send_arg(-1, 8'h00);
        put_string("42");          send_arg(-1, 8'h00);
        put_string("+42");         send_arg(-1, 8'h00);
        drive(KIND_CHAR, "1");
        drive(KIND_UNUSED, 8'haa);
        drive(KIND_CHAR, "7");
        drive(KIND_END, 8'h55);
        drive(KIND_CHAR, "1");
        drive(KIND_CHAR, "2");
        drive(KIND_NEW, 8'h5a);
        drive(KIND_CHAR, "3");
        drive(KIND_END, 8'ha5);
        pause_until_drained();

        // duplicate on a full list, then a new value on a full list
        fill_list(-256, -256);
        base = $urandom_range(0, 2000000000);
        fill_list(base, base + MAX_ENTRIES);
        pause_until_drained();

        start_items = items_sent;
        arg_no      = 0;
        while (items_sent - start_items < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                drive(KIND_NEW, 8'($urandom));
            else if (r < 6)
                drive(KIND_UNUSED, 8'($urandom));
            else if (r < 10)
            begin
                repeat ($urandom_range(1, 5))
                    drive(KIND_CHAR, pick_byte());
                if (r < 8)
                    drive(KIND_NEW, 8'($urandom));
                else
                    rand_arg();
            end
            else
                rand_arg();
            arg_no++;
            if (arg_no % 60 == 0)
                pause_until_drained();
        end
        in_valid <= 1'b0;

        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
